[design/sort_ids_by_key_assert.svh]
// ----------------------------------------------------------------------------
// sort_ids_by_key_assert.svh
// Assertion macros used by the checker file of the key sorter.
// ----------------------------------------------------------------------------
`ifndef SORT_IDS_BY_KEY_ASSERT_SVH
`define SORT_IDS_BY_KEY_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SIBK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sort_ids_by_key: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SIBK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sort_ids_by_key: next-cycle check failed");

`endif

[design/sibk_pkg.sv]
// ----------------------------------------------------------------------------
// sibk_pkg
// Shared types and constants of the key-ordered identifier sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sibk_pkg;

    // Default sizes
    localparam int SIBK_CAPACITY = 64;
    localparam int SIBK_KEY_BITS = 32;
    localparam int SIBK_ID_BITS  = 16;

    // Register map
    localparam int                    SIBK_ADDR_W          = 1;
    localparam logic [SIBK_ADDR_W-1:0] SIBK_ADDR_SORT_ORDER = 1'b0;

    // Sort directions
    localparam logic SIBK_ASCEND  = 1'b0;
    localparam logic SIBK_DESCEND = 1'b1;

    // Per-cycle command broadcast to every cell of a chain
    typedef struct packed {
        logic insert;   // place the incoming word into the chain
        logic shift;    // move every cell one place toward the head
        logic clear;    // drop all contents
    } sibk_ctrl_t;

endpackage

`default_nettype wire

[design/sibk_cell.sv]
// ----------------------------------------------------------------------------
// sibk_cell
// One insertion-sort cell: holds a key, an id and a valid bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sibk_cell #(
    parameter int KEY_BITS = 32,
    parameter int ID_BITS  = 16
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  sibk_pkg::sibk_ctrl_t     ctrl,
    input  wire                      descend,
    input  wire  [KEY_BITS-1:0]      new_key,
    input  wire  [ID_BITS-1:0]       new_id,
    input  wire                      prev_ins,
    input  wire                      prev_valid,
    input  wire  [KEY_BITS-1:0]      prev_key,
    input  wire  [ID_BITS-1:0]       prev_id,
    input  wire                      next_valid,
    input  wire  [KEY_BITS-1:0]      next_key,
    input  wire  [ID_BITS-1:0]       next_id,
    output logic                     ins,
    output logic                     valid,
    output logic [KEY_BITS-1:0]      key,
    output logic [ID_BITS-1:0]       id
);
    import sibk_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [ID_BITS-1:0]  id_reg;
    logic [ID_BITS-1:0]  id_next;
    logic                goes_first;

    // Strict compare keeps equal keys in arrival order
    assign goes_first = descend ? ($signed(new_key) > $signed(key_reg))
                                : ($signed(new_key) < $signed(key_reg));

    // Empty cells always accept; the chain stays sorted so ins is monotonic
    assign ins = !valid_reg || goes_first;

    // Next cell contents
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        id_next    = id_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = next_valid;
            key_next   = next_key;
            id_next    = next_id;
        end
        else if (ctrl.insert && ins)
        begin
            if (!prev_ins)
            begin
                // insertion point
                valid_next = 1'b1;
                key_next   = new_key;
                id_next    = new_id;
            end
            else
            begin
                // pushed down by the word above
                valid_next = prev_valid;
                key_next   = prev_key;
                id_next    = prev_id;
            end
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign id    = id_reg;

endmodule

`default_nettype wire

[design/sibk_chain.sv]
// ----------------------------------------------------------------------------
// sibk_chain
// Row of sort cells kept in order for one direction; drains from the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sibk_chain #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32,
    parameter int ID_BITS  = 16
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  sibk_pkg::sibk_ctrl_t     ctrl,
    input  wire                      descend,
    input  wire  [KEY_BITS-1:0]      new_key,
    input  wire  [ID_BITS-1:0]       new_id,
    output logic                     head_valid,
    output logic [KEY_BITS-1:0]      head_key,
    output logic [ID_BITS-1:0]       head_id,
    output logic                     second_valid,
    output logic                     tail_valid
);
    import sibk_pkg::*;

    // Link index g+1 is cell g; index 0 and CAPACITY+1 are the chain ends
    logic                lk_valid [CAPACITY+2];
    logic [KEY_BITS-1:0] lk_key   [CAPACITY+2];
    logic [ID_BITS-1:0]  lk_id    [CAPACITY+2];
    logic                lk_ins   [CAPACITY+1];

    // Chain ends: nothing above the head, nothing below the tail
    assign lk_valid[0]          = 1'b0;
    assign lk_key[0]            = '0;
    assign lk_id[0]             = '0;
    assign lk_ins[0]            = 1'b0;
    assign lk_valid[CAPACITY+1] = 1'b0;
    assign lk_key[CAPACITY+1]   = '0;
    assign lk_id[CAPACITY+1]    = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        sibk_cell #(
            .KEY_BITS (KEY_BITS),
            .ID_BITS  (ID_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .descend    (descend),
            .new_key    (new_key),
            .new_id     (new_id),
            .prev_ins   (lk_ins[g]),
            .prev_valid (lk_valid[g]),
            .prev_key   (lk_key[g]),
            .prev_id    (lk_id[g]),
            .next_valid (lk_valid[g+2]),
            .next_key   (lk_key[g+2]),
            .next_id    (lk_id[g+2]),
            .ins        (lk_ins[g+1]),
            .valid      (lk_valid[g+1]),
            .key        (lk_key[g+1]),
            .id         (lk_id[g+1])
        );
    end

    assign head_valid   = lk_valid[1];
    assign head_key     = lk_key[1];
    assign head_id      = lk_id[1];
    assign second_valid = lk_valid[2];
    assign tail_valid   = lk_valid[CAPACITY];

endmodule

`default_nettype wire

[design/sort_ids_by_key.sv]
// Loading: one entry word per cycle, no result until the last entry.
// Output: first result in the cycle after the last entry is accepted, then one
//   per cycle while m_tready is high; each accepted result shifts the cell
//   chain one place toward its head.
// No entry is taken while a run is being sent out.
// Reset: all cells empty, drop flag and sort_order cleared at once.
// ----------------------------------------------------------------------------
// sort_ids_by_key
// Insertion-sort cell chains that emit stored ids ordered by signed key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sort_ids_by_key #(
    parameter int CAPACITY = sibk_pkg::SIBK_CAPACITY,
    parameter int KEY_BITS = sibk_pkg::SIBK_KEY_BITS,
    parameter int ID_BITS  = sibk_pkg::SIBK_ID_BITS
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    // entry stream
    input  wire                                         s_tvalid,
    output logic                                        s_tready,
    // s_tdata: entry_id, sort_key, zero fill
    input  wire  [((ID_BITS+KEY_BITS+7)/8)*8-1:0]       s_tdata,
    input  wire                                         s_tlast,   // last_entry
    // result stream
    output logic                                        m_tvalid,
    input  wire                                         m_tready,
    // m_tdata: out_id, out_key, zero fill
    output logic [((ID_BITS+KEY_BITS+7)/8)*8-1:0]       m_tdata,
    output logic                                        m_tlast,   // last_result
    output logic                                        m_tuser,   // entries_dropped
    // configuration
    input  wire                                         psel,
    input  wire                                         penable,
    input  wire                                         pwrite,
    input  wire  [sibk_pkg::SIBK_ADDR_W-1:0]            paddr,
    input  wire  [31:0]                                 pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);
    import sibk_pkg::*;

    localparam int DATA_W = ((ID_BITS + KEY_BITS + 7) / 8) * 8;

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic                order_reg;
    logic                order_next;
    logic                overflow_reg;
    logic                overflow_next;
    logic                sort_order_reg;
    logic                sort_order_next;

    logic                s_acc;
    logic                m_acc;
    logic                full;
    sibk_ctrl_t          ctrl;

    logic [ID_BITS-1:0]  in_id;
    logic [KEY_BITS-1:0] in_key;

    logic                asc_head_valid;
    logic [KEY_BITS-1:0] asc_head_key;
    logic [ID_BITS-1:0]  asc_head_id;
    logic                asc_second_valid;
    logic                asc_tail_valid;
    logic                dsc_head_valid;
    logic [KEY_BITS-1:0] dsc_head_key;
    logic [ID_BITS-1:0]  dsc_head_id;
    logic                dsc_second_valid;
    logic                dsc_tail_valid;

    logic                sel_valid;
    logic [KEY_BITS-1:0] sel_key;
    logic [ID_BITS-1:0]  sel_id;
    logic                sel_second;

    // Configuration port
    assign pready = 1'b1;

    always_comb
    begin
        sort_order_next = sort_order_reg;
        if (psel && penable && pwrite && pready && (paddr == SIBK_ADDR_SORT_ORDER))
            sort_order_next = pwdata[0];
    end

    assign prdata = (paddr == SIBK_ADDR_SORT_ORDER) ? {31'b0, sort_order_reg} : 32'b0;

    // Input fields
    assign in_id  = s_tdata[ID_BITS-1:0];
    assign in_key = s_tdata[ID_BITS +: KEY_BITS];

    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign full     = asc_tail_valid || dsc_tail_valid;

    // Both chains see the same command; the direction picks one at drain time
    always_comb
    begin
        ctrl.insert = s_acc && !full;
        ctrl.shift  = m_acc;
        ctrl.clear  = m_acc && m_tlast;
    end

    sibk_chain #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .ID_BITS  (ID_BITS)
    ) u_asc (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .descend      (SIBK_ASCEND),
        .new_key      (in_key),
        .new_id       (in_id),
        .head_valid   (asc_head_valid),
        .head_key     (asc_head_key),
        .head_id      (asc_head_id),
        .second_valid (asc_second_valid),
        .tail_valid   (asc_tail_valid)
    );

    sibk_chain #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .ID_BITS  (ID_BITS)
    ) u_dsc (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .descend      (SIBK_DESCEND),
        .new_key      (in_key),
        .new_id       (in_id),
        .head_valid   (dsc_head_valid),
        .head_key     (dsc_head_key),
        .head_id      (dsc_head_id),
        .second_valid (dsc_second_valid),
        .tail_valid   (dsc_tail_valid)
    );

    // Head of the chain chosen for this run
    assign sel_valid  = (order_reg == SIBK_DESCEND) ? dsc_head_valid   : asc_head_valid;
    assign sel_key    = (order_reg == SIBK_DESCEND) ? dsc_head_key     : asc_head_key;
    assign sel_id     = (order_reg == SIBK_DESCEND) ? dsc_head_id      : asc_head_id;
    assign sel_second = (order_reg == SIBK_DESCEND) ? dsc_second_valid : asc_second_valid;

    assign m_tvalid = (state_reg == ST_DRAIN) && sel_valid;
    assign m_tdata  = DATA_W'({sel_key, sel_id});
    assign m_tlast  = !sel_second;
    assign m_tuser  = overflow_reg;

    // Load / drain sequencing
    always_comb
    begin
        state_next    = state_reg;
        order_next    = order_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_acc)
                begin
                    overflow_next = overflow_reg || full;
                    if (s_tlast)
                    begin
                        state_next = ST_DRAIN;
                        order_next = sort_order_reg;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (m_acc && m_tlast)
                begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            order_reg      <= SIBK_ASCEND;
            overflow_reg   <= 1'b0;
            sort_order_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            order_reg      <= order_next;
            overflow_reg   <= overflow_next;
            sort_order_reg <= sort_order_next;
        end
    end

endmodule

`default_nettype wire

[design/sibk_checker.sv]
// ----------------------------------------------------------------------------
// sibk_checker
// Port-level checks of the key sorter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sort_ids_by_key_assert.svh"

module sibk_checker #(
    parameter int KEY_BITS = sibk_pkg::SIBK_KEY_BITS,
    parameter int ID_BITS  = sibk_pkg::SIBK_ID_BITS
) (
    input wire                                      clk,
    input wire                                      rst_n,
    input wire                                      s_tvalid,
    input wire                                      s_tready,
    input wire                                      s_tlast,
    input wire                                      m_tvalid,
    input wire                                      m_tready,
    input wire [((ID_BITS+KEY_BITS+7)/8)*8-1:0]     m_tdata,
    input wire                                      m_tlast,
    input wire                                      m_tuser
);
    import sibk_pkg::*;

    // Entries are never taken while a run is being sent
    `SIBK_ASSERT_NOW(a_no_overlap, clk, rst_n, m_tvalid, !s_tready)

    // A last entry always starts a run on the next cycle
    `SIBK_ASSERT_NEXT(a_run_starts, clk, rst_n, s_tvalid && s_tready && s_tlast, m_tvalid)

    // The store is empty once the final result is taken
    `SIBK_ASSERT_NEXT(a_run_ends, clk, rst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)

    // The drop flag is the same on every result of a run
    `SIBK_ASSERT_NEXT(a_drop_steady, clk, rst_n, m_tvalid && m_tready && !m_tlast,
                      m_tuser == $past(m_tuser))

    // A stalled result holds
    `SIBK_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind sort_ids_by_key sibk_checker #(
    .KEY_BITS (KEY_BITS),
    .ID_BITS  (ID_BITS)
) u_sibk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
